@@ hw/rtl/bcdalu_pkg.sv @@
// Shared types and constants for the binary/BCD add-subtract ALU pipeline.
`default_nettype none

package bcdalu_pkg;

	// Operation codes
	localparam logic OP_ADC = 1'b0;
	localparam logic OP_SBC = 1'b1;

	// Decimal correction constants
	localparam logic [3:0] BCD_FIX = 4'd6;
	localparam logic [4:0] BCD_MAX = 5'd9;

	// One command item
	typedef struct packed {
		logic       opcode;
		logic [7:0] accumulator;
		logic [7:0] operand;
		logic       carry_in;
		logic       decimal_mode;
	} alu_cmd_t;

	// One result item
	typedef struct packed {
		logic [7:0] result;
		logic       negative;
		logic       overflow;
		logic       zero;
		logic       carry_out;
	} alu_rsp_t;

	// Stage 1 -> stage 2: raw byte sum and low nibble sum
	typedef struct packed {
		logic       op;
		logic       dec;
		logic       a_sign;
		logic       m_sign;
		logic [3:0] a_hi;
		logic [3:0] m_hi;
		logic [8:0] bin;
		logic [4:0] lo;
	} alu_sum_t;

	// Stage 2 -> stage 3: corrected low digit, raw high nibble, flags
	typedef struct packed {
		logic       op;
		logic       dec;
		logic [7:0] bin_byte;
		logic [3:0] lo_digit;
		logic [4:0] hi;
		logic       negative;
		logic       overflow;
		logic       zero;
		logic       carry_bin;
	} alu_digit_t;

endpackage

`default_nettype wire

@@ hw/rtl/bcdalu_sum.sv @@
// Stage 1: byte adder and low nibble adder, operand inverted for subtract.
`default_nettype none

module bcdalu_sum (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   valid_in,
	input  bcdalu_pkg::alu_cmd_t  cmd,
	output logic                  valid_s1,
	output bcdalu_pkg::alu_sum_t  sum_s1
);
	import bcdalu_pkg::*;

	logic [7:0] mm;
	alu_sum_t   sum_d;

	// Subtract is A + ~M + C; the carry in bit 8 is then not-borrow
	always_comb begin
		mm           = (cmd.opcode == OP_SBC) ? ~cmd.operand : cmd.operand;
		sum_d.op     = cmd.opcode;
		sum_d.dec    = cmd.decimal_mode;
		sum_d.a_sign = cmd.accumulator[7];
		sum_d.m_sign = mm[7];
		sum_d.a_hi   = cmd.accumulator[7:4];
		sum_d.m_hi   = mm[7:4];
		sum_d.bin    = {1'b0, cmd.accumulator} + {1'b0, mm} + {8'b0, cmd.carry_in};
		sum_d.lo     = {1'b0, cmd.accumulator[3:0]} + {1'b0, mm[3:0]}
			+ {4'b0, cmd.carry_in};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		sum_s1 <= sum_d;
	end

endmodule

`default_nettype wire

@@ hw/rtl/bcdalu_digit.sv @@
// Stage 2: low digit correction, raw high nibble sum and N/V/Z flags.
`default_nettype none

module bcdalu_digit (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     valid_s1,
	input  bcdalu_pkg::alu_sum_t    sum_s1,
	output logic                    valid_s2,
	output bcdalu_pkg::alu_digit_t  dig_s2
);
	import bcdalu_pkg::*;

	logic       lo_carry;
	logic [3:0] lo_digit;
	logic [4:0] hi_sum;
	logic       sign;
	logic       zero;
	alu_digit_t dig_d;

	// Low digit: add corrects above nine, subtract corrects on borrow
	always_comb begin
		unique case (sum_s1.op)
			OP_SBC: begin
				lo_carry = sum_s1.lo[4];
				lo_digit = sum_s1.lo[4] ? sum_s1.lo[3:0] : sum_s1.lo[3:0] - BCD_FIX;
			end
			default: begin
				lo_carry = (sum_s1.lo > BCD_MAX);
				lo_digit = lo_carry ? sum_s1.lo[3:0] + BCD_FIX : sum_s1.lo[3:0];
			end
		endcase
		hi_sum = {1'b0, sum_s1.a_hi} + {1'b0, sum_s1.m_hi} + {4'b0, lo_carry};
	end

	// Flags; decimal add takes its sign from the uncorrected high nibble
	always_comb begin
		zero = (sum_s1.bin[7:0] == 8'h00);
		sign = (sum_s1.dec && sum_s1.op == OP_ADC) ? hi_sum[3] : sum_s1.bin[7];
		dig_d.op        = sum_s1.op;
		dig_d.dec       = sum_s1.dec;
		dig_d.bin_byte  = sum_s1.bin[7:0];
		dig_d.lo_digit  = lo_digit;
		dig_d.hi        = hi_sum;
		dig_d.zero      = zero;
		dig_d.negative  = !zero && sign;
		dig_d.overflow  = !(sum_s1.a_sign ^ sum_s1.m_sign) && (sum_s1.a_sign ^ sign);
		dig_d.carry_bin = sum_s1.bin[8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		dig_s2 <= dig_d;
	end

endmodule

`default_nettype wire

@@ hw/rtl/bcdalu_adjust.sv @@
// Stage 3: high digit correction, decimal carry and result assembly.
`default_nettype none

module bcdalu_adjust (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     valid_s2,
	input  bcdalu_pkg::alu_digit_t  dig_s2,
	output logic                    valid_s3,
	output bcdalu_pkg::alu_rsp_t    rsp_s3
);
	import bcdalu_pkg::*;

	logic       hi_gt9;
	logic [3:0] hi_digit;
	alu_rsp_t   rsp_d;

	always_comb begin
		hi_gt9            = (dig_s2.hi > BCD_MAX);
		hi_digit          = dig_s2.hi[3:0];
		rsp_d.negative    = dig_s2.negative;
		rsp_d.overflow    = dig_s2.overflow;
		rsp_d.zero        = dig_s2.zero;
		rsp_d.carry_out   = dig_s2.carry_bin;
		rsp_d.result      = dig_s2.bin_byte;
		if (dig_s2.dec) begin
			unique case (dig_s2.op)
				OP_SBC: begin
					// negative high nibble difference takes -6
					if (!dig_s2.hi[4]) begin
						hi_digit = dig_s2.hi[3:0] - BCD_FIX;
					end
				end
				default: begin
					// above nine takes +6 and then always carries
					if (hi_gt9) begin
						hi_digit = dig_s2.hi[3:0] + BCD_FIX;
					end
					rsp_d.carry_out = hi_gt9;
				end
			endcase
			rsp_d.result = {hi_digit, dig_s2.lo_digit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		rsp_s3 <= rsp_d;
	end

endmodule

`default_nettype wire

@@ hw/rtl/binary_bcd_add_subtract_alu.sv @@
// Top level of the binary/BCD add-subtract ALU: three-stage pipeline.
//
// Usage:
//   Commands enter on cmd, taken at a rising edge where start is high and
//   busy is low. busy is held low: a command may be issued every cycle.
//   Each command yields exactly one result on rsp, marked by done for
//   one cycle, once it has passed through every register stage.
//   Throughput is one item per cycle; the three register stages are
//   byte/low-nibble add, low digit fix plus high nibble add and flags,
//   then high digit fix and result assembly.
//   The result side cannot stall; results are in order and must be taken
//   in the cycle done is high.
//   Reset (arst_n low) clears the stage valid bits, so items in flight are
//   dropped and done stays low until new commands arrive. There is no other
//   state.
`default_nettype none

module binary_bcd_add_subtract_alu (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	output logic                  busy,
	input  bcdalu_pkg::alu_cmd_t  cmd,
	output logic                  done,
	output bcdalu_pkg::alu_rsp_t  rsp
);
	import bcdalu_pkg::*;

	logic       valid_s1;
	logic       valid_s2;
	logic       valid_s3;
	alu_sum_t   sum_s1;
	alu_digit_t dig_s2;
	alu_rsp_t   rsp_s3;

	assign busy = 1'b0;

	bcdalu_sum u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (start && !busy),
		.cmd      (cmd),
		.valid_s1 (valid_s1),
		.sum_s1   (sum_s1)
	);

	bcdalu_digit u_digit (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.sum_s1   (sum_s1),
		.valid_s2 (valid_s2),
		.dig_s2   (dig_s2)
	);

	bcdalu_adjust u_adjust (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.dig_s2   (dig_s2),
		.valid_s3 (valid_s3),
		.rsp_s3   (rsp_s3)
	);

	assign done = valid_s3;
	assign rsp  = rsp_s3;

`ifndef ASSERT_OFF
	// every result traces back to a command taken earlier
	a_done_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 3))
		else $error("result without a command");

	// every command yields a result on done
	a_cmd_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##3 done)
		else $error("command lost in pipeline");

	// binary add result matches a plain byte add
	a_bin_add: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !$past(cmd.decimal_mode, 3) && ($past(cmd.opcode, 3) == OP_ADC))
		|-> (rsp.result == 8'($past(cmd.accumulator, 3) + $past(cmd.operand, 3)
			+ {7'b0, $past(cmd.carry_in, 3)})))
		else $error("binary add result mismatch");

	// zero flag forces negative clear
	a_zero_not_neg: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.zero) |-> !rsp.negative)
		else $error("negative set with zero");
`endif

endmodule

`default_nettype wire
